// ----- rtl/hsvck_pkg.sv -----
// Shared types, constants and the divider step for the HSV chroma key block.
// No dependencies; imported by hsvck_div_pipe, the top level and the testbench.
package hsvck_pkg;

	localparam int unsigned PIX_W     = 8;
	localparam int unsigned CFG_W     = 15;
	localparam int unsigned SAT_Q_W   = 15;
	localparam int unsigned HUE_Q_W   = 12;
	localparam int unsigned DIV_STEPS = SAT_Q_W;
	// The hue quotient is narrower, so its lane starts this many stages late.
	localparam int unsigned HUE_SKIP  = SAT_Q_W - HUE_Q_W;

	localparam logic [CFG_W-1:0] HUE_FULL      = 15'd23040;
	localparam logic [CFG_W-1:0] HUE_OFS_GREEN = 15'd7680;
	localparam logic [CFG_W-1:0] HUE_OFS_BLUE  = 15'd15360;

	typedef enum logic [2:0] {
		REG_HUE_CENTER = 3'd0,
		REG_HUE_SPAN   = 3'd1,
		REG_SAT_CENTER = 3'd2,
		REG_SAT_SPAN   = 3'd3,
		REG_VAL_CENTER = 3'd4,
		REG_VAL_SPAN   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// Red sits in the lowest bits of the packed pixel.
	typedef struct packed {
		logic [PIX_W-1:0] alpha;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pix_t;

	typedef struct packed {
		pix_t               pix;
		sector_t            sector;
		logic               hue_neg;
		logic               hue_zero;
		logic               sat_zero;
		logic [CFG_W-1:0]   val;
		logic [7:0]         sat_den;
		logic [7:0]         sat_rem;
		logic               sat_lsb;
		logic [SAT_Q_W-1:0] sat_q;
		logic [7:0]         hue_den;
		logic [7:0]         hue_rem;
		logic [3:0]         hue_low;
		logic [HUE_Q_W-1:0] hue_q;
	} div_item_t;

	// One restoring division step: returns {quotient bit, new remainder}.
	// The remainder stays below the divisor, so eight bits hold it.
	function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
		input logic [7:0] den);
		logic [8:0] t;
		logic [8:0] d;
		t = {rem, nbit};
		d = {1'b0, den};
		if (t >= d) begin
			div_step = {1'b1, 8'(t - d)};
		end else begin
			div_step = {1'b0, t[7:0]};
		end
	endfunction

endpackage

// ----- rtl/hsvck_div_pipe.sv -----
// Pipelined restoring divider: saturation and hue quotients, one bit per stage.
// Depends on hsvck_pkg for the item type and the division step.
module hsvck_div_pipe (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hsvck_pkg::div_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hsvck_pkg::div_item_t  out_item
);
	import hsvck_pkg::*;

	div_item_t            item_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] vld_s;
	logic [DIV_STEPS:0]   rdy;

	assign rdy[DIV_STEPS] = out_ready;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
		div_item_t prev;
		div_item_t nxt;
		logic      prev_vld;

		if (k == 0) begin : g_first
			assign prev     = in_item;
			assign prev_vld = in_valid;
		end else begin : g_next
			assign prev     = item_s[k-1];
			assign prev_vld = vld_s[k-1];
		end

		always_comb begin
			logic [8:0] sat_r;
			logic [8:0] hue_r;
			nxt         = prev;
			sat_r       = div_step(prev.sat_rem, prev.sat_lsb, prev.sat_den);
			nxt.sat_rem = sat_r[7:0];
			nxt.sat_lsb = 1'b0;
			nxt.sat_q   = {prev.sat_q[SAT_Q_W-2:0], sat_r[8]};
			hue_r       = div_step(prev.hue_rem, prev.hue_low[3], prev.hue_den);
			if (k >= HUE_SKIP) begin
				nxt.hue_rem = hue_r[7:0];
				nxt.hue_low = {prev.hue_low[2:0], 1'b0};
				nxt.hue_q   = {prev.hue_q[HUE_Q_W-2:0], hue_r[8]};
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prev_vld) begin
				item_s[k] <= nxt;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[DIV_STEPS-1];
	assign out_item  = item_s[DIV_STEPS-1];

endmodule

// ----- rtl/hsv_chroma_key_alpha_mask_top.sv -----
// Top level of the HSV chroma key: RGB to HSV conversion, window test, alpha mask.
// Depends on hsvck_pkg and hsvck_div_pipe.

// The block takes one RGBA pixel per clock unless the output stalls, and returns it with
// alpha cleared when hue, saturation and value all fall strictly inside their programmed
// windows. The pipeline has one stage for the channel maximum and minimum, fifteen
// stages of the restoring divider that forms saturation and hue one quotient bit per
// stage, one stage that finishes the hue and one output stage for the window test.
// Every stage has its own valid bit, so bubbles close up when the output stalls.
// Window registers are written through the cfg port, which is always ready; write them
// only while no pixel is in flight.
module hsv_chroma_key_alpha_mask_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	import hsvck_pkg::*;

	function automatic logic in_window(input logic [CFG_W-1:0] x,
		input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] s);
		logic [CFG_W+1:0] xs;
		logic [CFG_W+1:0] cs;
		xs = {2'b00, x} + {2'b00, s};
		cs = {2'b00, c} + {2'b00, s};
		// center - span < x is rewritten as center < x + span.
		in_window = (xs > {2'b00, c}) && ({2'b00, x} < cs);
	endfunction

	logic [CFG_W-1:0] hue_center_q, hue_span_q, sat_center_q, sat_span_q;
	logic [CFG_W-1:0] val_center_q, val_span_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_center_q <= 15'd7680;
			hue_span_q   <= 15'd3520;
			sat_center_q <= 15'd16384;
			sat_span_q   <= 15'd10649;
			val_center_q <= 15'd16384;
			val_span_q   <= 15'd13926;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_HUE_CENTER: hue_center_q <= cfg_data;
				REG_HUE_SPAN:   hue_span_q   <= cfg_data;
				REG_SAT_CENTER: sat_center_q <= cfg_data;
				REG_SAT_SPAN:   sat_span_q   <= cfg_data;
				REG_VAL_CENTER: val_center_q <= cfg_data;
				REG_VAL_SPAN:   val_span_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: maximum, minimum and the sector that holds the maximum.
	pix_t       in_pix;
	logic [7:0] mx_c, mn_c;
	sector_t    sec_c;

	assign in_pix = pix_t'(s_axis_tdata);

	always_comb begin
		if (in_pix.red >= in_pix.green && in_pix.red >= in_pix.blue) begin
			sec_c = SEC_RED;
			mx_c  = in_pix.red;
		end else if (in_pix.green >= in_pix.blue) begin
			sec_c = SEC_GREEN;
			mx_c  = in_pix.green;
		end else begin
			sec_c = SEC_BLUE;
			mx_c  = in_pix.blue;
		end
		mn_c = in_pix.red;
		if (in_pix.green < mn_c) begin
			mn_c = in_pix.green;
		end
		if (in_pix.blue < mn_c) begin
			mn_c = in_pix.blue;
		end
	end

	pix_t       pix_s1;
	logic [7:0] mx_s1, mn_s1;
	sector_t    sec_s1;
	logic       vld_s1;
	logic       div_in_ready;

	assign s_axis_tready = !vld_s1 || div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pix_s1 <= in_pix;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sec_s1 <= sec_c;
		end
	end

	// Divider setup: delta, signed channel difference, value and first remainders.
	div_item_t   div_in;
	logic [7:0]  delta;
	logic [8:0]  diff;
	logic [7:0]  diff_abs;
	logic [11:0] hue_num;
	logic [13:0] m64;
	logic [14:0] v_t;

	always_comb begin
		delta = mx_s1 - mn_s1;
		case (sec_s1)
			SEC_RED:   diff = {1'b0, pix_s1.green} - {1'b0, pix_s1.blue};
			SEC_GREEN: diff = {1'b0, pix_s1.blue} - {1'b0, pix_s1.red};
			default:   diff = {1'b0, pix_s1.red} - {1'b0, pix_s1.green};
		endcase
		diff_abs = diff[8] ? 8'(-diff) : diff[7:0];
		// 3840 * d = (15 * d) << 8; the shift becomes eight extra divider steps.
		hue_num = {diff_abs, 4'b0000} - {4'b0000, diff_abs};
		// 16384 * m / 255 = 64 * m + floor(64 * m / 255).
		m64 = {mx_s1, 6'b000000};
		v_t = {1'b0, m64} + {9'b0, m64[13:8]} + 15'd1;

		div_in          = '0;
		div_in.pix      = pix_s1;
		div_in.sector   = sec_s1;
		div_in.hue_neg  = diff[8];
		div_in.hue_zero = (delta == 8'd0);
		div_in.sat_zero = (mx_s1 == 8'd0);
		div_in.val      = {1'b0, m64} + {8'b0, v_t[14:8]};
		div_in.sat_den  = mx_s1;
		div_in.sat_rem  = {1'b0, delta[7:1]};
		div_in.sat_lsb  = delta[0];
		div_in.hue_den  = delta;
		div_in.hue_rem  = hue_num[11:4];
		div_in.hue_low  = hue_num[3:0];
	end

	div_item_t div_out;
	logic      div_out_valid;
	logic      rdy_s17;

	hsvck_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (div_in_ready),
		.in_item   (div_in),
		.out_valid (div_out_valid),
		.out_ready (rdy_s17),
		.out_item  (div_out)
	);

	// Hue assembly: sector offset plus or minus the quotient, wrapped at full circle.
	logic [CFG_W-1:0]   hue_ofs;
	logic [HUE_Q_W-1:0] hue_q;
	logic [15:0]        hue_sum;
	logic [CFG_W-1:0]   hue_c;
	logic [CFG_W-1:0]   sat_c;

	always_comb begin
		case (div_out.sector)
			SEC_RED:   hue_ofs = '0;
			SEC_GREEN: hue_ofs = HUE_OFS_GREEN;
			default:   hue_ofs = HUE_OFS_BLUE;
		endcase
		hue_q   = div_out.hue_zero ? '0 : div_out.hue_q;
		hue_sum = div_out.hue_neg ? ({1'b0, hue_ofs} - {4'b0000, hue_q})
		                          : ({1'b0, hue_ofs} + {4'b0000, hue_q});
		hue_c   = hue_sum[15] ? 15'(hue_sum + {1'b0, HUE_FULL}) : hue_sum[14:0];
		if (div_out.hue_zero) begin
			hue_c = '0;
		end
		sat_c = div_out.sat_zero ? '0 : div_out.sat_q;
	end

	pix_t             pix_s17;
	logic [CFG_W-1:0] hue_s17, sat_s17, val_s17;
	logic             vld_s17;
	logic             rdy_s18;

	assign rdy_s17 = !vld_s17 || rdy_s18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s17 <= 1'b0;
		end else if (rdy_s17) begin
			vld_s17 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s17 && div_out_valid) begin
			pix_s17 <= div_out.pix;
			hue_s17 <= hue_c;
			sat_s17 <= sat_c;
			val_s17 <= div_out.val;
		end
	end

	// Output stage: window test and alpha mask.
	pix_t pix_s18;
	pix_t key_pix;
	logic vld_s18;
	logic keyed;

	assign rdy_s18 = !vld_s18 || m_axis_tready;

	always_comb begin
		keyed   = in_window(hue_s17, hue_center_q, hue_span_q) &&
		          in_window(sat_s17, sat_center_q, sat_span_q) &&
		          in_window(val_s17, val_center_q, val_span_q);
		key_pix = pix_s17;
		if (keyed) begin
			key_pix.alpha = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s18 <= 1'b0;
		end else if (rdy_s18) begin
			vld_s18 <= vld_s17;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s18 && vld_s17) begin
			pix_s18 <= key_pix;
		end
	end

	assign m_axis_tvalid = vld_s18;
	assign m_axis_tdata  = pix_s18;

`ifndef ASSERT_OFF
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s17 |-> hue_s17 < HUE_FULL)
		else $error("hue out of range");

	a_sat_val_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s17 |-> (sat_s17 <= 15'd16384) && (val_s17 <= 15'd16384))
		else $error("saturation or value out of range");

	a_hue_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(div_out_valid && !div_out.hue_zero) |-> div_out.hue_q <= 12'd3840)
		else $error("hue quotient exceeds one sector");

	a_color_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s17 && rdy_s18) |=> m_axis_tdata[23:0] == $past(pix_s17[23:0]))
		else $error("color channels changed in the output stage");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hsv_chroma_key_alpha_mask_top: RGBA pixels in, keyed pixels out.
// Depends on hsvck_pkg for the pixel layout, register indexes and hue constants.
module tb_top;
	import hsvck_pkg::*;

	localparam int PIPE_LATENCY = 18;
	localparam int LIMIT_CYCLES = 200000;
	localparam int IDLE_PCT     = 29;
	localparam int HUE_SECTOR   = 3840;
	localparam int FIX_ONE      = 16384;
	localparam int CHAN_MAX     = 255;
	localparam int SV_MAX       = 32767;

	localparam logic [CFG_W-1:0] HUE_CENTER_RST = 15'd7680;
	localparam logic [CFG_W-1:0] HUE_SPAN_RST   = 15'd3520;
	localparam logic [CFG_W-1:0] SAT_CENTER_RST = 15'd16384;
	localparam logic [CFG_W-1:0] SAT_SPAN_RST   = 15'd10649;
	localparam logic [CFG_W-1:0] VAL_CENTER_RST = 15'd16384;
	localparam logic [CFG_W-1:0] VAL_SPAN_RST   = 15'd13926;

	// Indexes past the last register; writes to them must leave the window alone.
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [2:0]       idx;
		logic [CFG_W-1:0] data;
	} reg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;

	pix_t             pending_pix [$];
	pix_t             expected_pix [$];
	reg_write_t       pending_writes [$];
	logic [CFG_W-1:0] window_reg [0:5];
	pix_t             seen_pix;
	pix_t             want_pix;
	string            chan_name [4] = '{"red", "green", "blue", "alpha"};
	bit               calm = 1'b0;
	int               errors = 0;
	int               cycle_count = 0;

	hsv_chroma_key_alpha_mask_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit strictly_between(input int x, input logic [CFG_W-1:0] center,
		input logic [CFG_W-1:0] span);
		int c;
		int s;
		c = center;
		s = span;
		return (x < c + s) && (x > c - s);
	endfunction

	// Converts the pixel to fixed-point HSV and clears alpha when all three hit the window.
	function automatic pix_t keyed_pixel(input pix_t p);
		int   r, g, b, mx, mn, delta, hue, sat, val, ofs, diff;
		pix_t q;
		r = p.red;
		g = p.green;
		b = p.blue;
		mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		delta = mx - mn;
		val = (FIX_ONE * mx) / CHAN_MAX;
		hue = 0;
		sat = 0;
		if (mx != 0) begin
			sat = (FIX_ONE * delta) / mx;
			if (delta != 0) begin
				if (r == mx) begin
					ofs = 0;
					diff = g - b;
				end else if (g == mx) begin
					ofs = int'(HUE_OFS_GREEN);
					diff = b - r;
				end else begin
					ofs = int'(HUE_OFS_BLUE);
					diff = r - g;
				end
				// Integer division truncates toward zero, which the hue format requires.
				hue = ofs + (HUE_SECTOR * diff) / delta;
				if (hue < 0) begin
					hue += int'(HUE_FULL);
				end
			end
		end
		q = p;
		if (strictly_between(hue, window_reg[REG_HUE_CENTER], window_reg[REG_HUE_SPAN]) &&
			strictly_between(sat, window_reg[REG_SAT_CENTER], window_reg[REG_SAT_SPAN]) &&
			strictly_between(val, window_reg[REG_VAL_CENTER], window_reg[REG_VAL_SPAN])) begin
			q.alpha = '0;
		end
		return q;
	endfunction

	function automatic pix_t rgba(input int r, input int g, input int b, input int a);
		pix_t p;
		p.red = 8'(r);
		p.green = 8'(g);
		p.blue = 8'(b);
		p.alpha = 8'(a);
		return p;
	endfunction

	// Half are green-dominant, grey or tied colors, since those reach the window and the tie
	// rules; one in ten is near black, one in ten has alpha 0 or FF, the rest uniform noise.
	function automatic pix_t next_pixel();
		pix_t        p;
		int unsigned kind;
		logic [7:0]  top;
		p = $urandom();
		kind = $urandom_range(9);
		case (kind)
			3, 4, 5: begin
				top = 8'($urandom_range(255, 60));
				p.green = top;
				p.red = 8'($urandom_range(top));
				p.blue = 8'($urandom_range(top));
			end
			6: begin
				p.green = p.red;
				p.blue = p.red;
			end
			7: begin
				case ($urandom_range(2))
					0: p.green = p.red;
					1: p.blue = p.green;
					default: p.blue = p.red;
				endcase
			end
			8: begin
				p.red = 8'($urandom_range(3));
				p.green = 8'($urandom_range(3));
				p.blue = 8'($urandom_range(3));
			end
			9: begin
				p.alpha = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	task automatic queue_random_pixels(input int count);
		for (int i = 0; i < count; i++) begin
			pending_pix.push_back(next_pixel());
		end
	endtask

	task automatic wait_drained();
		while (pending_pix.size() != 0 || s_axis_tvalid || expected_pix.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Every reprogramming also writes one spare index, which the block must ignore.
	task automatic program_window(input int hc, input int hs, input int sc, input int ss,
		input int vc, input int vs);
		reg_write_t w;
		wait_drained();
		w.idx = $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
		w.data = 15'($urandom());
		pending_writes.push_back(w);
		pending_writes.push_back(reg_write_t'{3'(REG_HUE_CENTER), 15'(hc)});
		pending_writes.push_back(reg_write_t'{3'(REG_HUE_SPAN), 15'(hs)});
		pending_writes.push_back(reg_write_t'{3'(REG_SAT_CENTER), 15'(sc)});
		pending_writes.push_back(reg_write_t'{3'(REG_SAT_SPAN), 15'(ss)});
		pending_writes.push_back(reg_write_t'{3'(REG_VAL_CENTER), 15'(vc)});
		pending_writes.push_back(reg_write_t'{3'(REG_VAL_SPAN), 15'(vs)});
		while (pending_writes.size() != 0 || cfg_valid) begin
			@(posedge clk);
		end
	endtask

	// Register write driver; the window copy follows each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			window_reg[REG_HUE_CENTER] <= HUE_CENTER_RST;
			window_reg[REG_HUE_SPAN] <= HUE_SPAN_RST;
			window_reg[REG_SAT_CENTER] <= SAT_CENTER_RST;
			window_reg[REG_SAT_SPAN] <= SAT_SPAN_RST;
			window_reg[REG_VAL_CENTER] <= VAL_CENTER_RST;
			window_reg[REG_VAL_SPAN] <= VAL_SPAN_RST;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index <= REG_VAL_SPAN) begin
				window_reg[cfg_index] <= cfg_data;
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_writes.size() != 0) begin
					cfg_valid <= 1'b1;
					{cfg_index, cfg_data} <= pending_writes.pop_front();
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Pixel driver: predicts the keyed pixel for each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_pix.push_back(keyed_pixel(s_axis_tdata));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_pix.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_pix.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random backpressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_pix = m_axis_tdata;
				if (expected_pix.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, seen_pix);
					errors++;
				end else begin
					want_pix = expected_pix.pop_front();
					for (int f = 0; f < 4; f++) begin
						if (seen_pix[8*f +: 8] !== want_pix[8*f +: 8]) begin
							$display("%0t: %s mismatch, expected %0d actual %0d", $time,
								chan_name[f], want_pix[8*f +: 8], seen_pix[8*f +: 8]);
							errors++;
						end
					end
				end
			end
			m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset window: black, grey, primaries, ties, hue wrap-around and keyed greens.
		pending_pix.push_back(rgba(0, 0, 0, 255));
		pending_pix.push_back(rgba(0, 0, 0, 0));
		pending_pix.push_back(rgba(255, 255, 255, 255));
		pending_pix.push_back(rgba(128, 128, 128, 77));
		pending_pix.push_back(rgba(255, 0, 0, 255));
		pending_pix.push_back(rgba(0, 255, 0, 255));
		pending_pix.push_back(rgba(0, 0, 255, 255));
		pending_pix.push_back(rgba(255, 255, 0, 200));
		pending_pix.push_back(rgba(0, 255, 255, 200));
		pending_pix.push_back(rgba(255, 0, 255, 200));
		pending_pix.push_back(rgba(255, 0, 1, 255));
		pending_pix.push_back(rgba(200, 0, 199, 170));
		pending_pix.push_back(rgba(0, 200, 0, 255));
		pending_pix.push_back(rgba(40, 200, 30, 85));
		pending_pix.push_back(rgba(0, 128, 0, 0));
		pending_pix.push_back(rgba(1, 0, 0, 255));
		pending_pix.push_back(rgba(0, 1, 0, 255));
		pending_pix.push_back(rgba(1, 1, 2, 1));
		pending_pix.push_back(rgba(255, 254, 253, 254));
		pending_pix.push_back(rgba(100, 200, 255, 128));
		queue_random_pixels(130);

		// Zero spans key nothing.
		program_window(0, 0, 0, 0, 0, 0);
		queue_random_pixels(110);

		// Top of every range.
		program_window(HUE_FULL, HUE_FULL, SV_MAX, SV_MAX, SV_MAX, SV_MAX);
		queue_random_pixels(110);

		// Centers at zero with full spans key every pixel, black and grey included.
		program_window(0, HUE_FULL, 0, SV_MAX, 0, SV_MAX);
		queue_random_pixels(110);

		for (int k = 0; k < 5; k++) begin
			program_window($urandom_range(HUE_FULL), $urandom_range(12000, 800),
				$urandom_range(SV_MAX), $urandom_range(20000, 2000),
				$urandom_range(SV_MAX), $urandom_range(20000, 2000));
			calm = (k == 1);
			if (k == 2) begin
				queue_random_pixels(55);
				wait_drained();
				queue_random_pixels(55);
			end else begin
				queue_random_pixels(110);
			end
		end

		wait_drained();
		calm = 1'b0;
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
